/* rtl/bfa_pkg.sv */
package bfa_pkg;

	// Map geometry.
	localparam int MAP_UNITS = 131072;
	localparam int WORD_BITS = 64;
	localparam int NUM_WORDS = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;

	localparam int ADDR_W = $clog2(NUM_WORDS);
	localparam int CNT_W  = $clog2(NUM_WORDS + 1);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int UNIT_W = $clog2(NUM_WORDS * WORD_BITS + 1);

	// Stream payload widths.
	localparam int FOUND_W   = 17;
	localparam int CMP_W     = (UNIT_W > FOUND_W) ? UNIT_W : FOUND_W;
	localparam int TDATA_W   = ((FOUND_W + 7) / 8) * 8;
	localparam int TUSER_W   = 2;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_FIND  = 2'd1,
		ACT_MARK  = 2'd2,
		ACT_ALLOC = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic sweep_init;
		logic clr_step;
		logic scan_step;
		logic scan_commit;
		logic mark_rd;
		logic mark_wr;
		logic res_ok;
		logic res_full;
		logic res_range;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t act;
		logic    idx_ok;
		logic    sweep_last;
		logic    hit;
		logic    exhausted;
	} dp_stat_t;

endpackage

/* rtl/bfa_dpath.sv */
module bfa_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfa_pkg::dp_cmd_t             cmd,
	output bfa_pkg::dp_stat_t            stat,
	input  logic [bfa_pkg::TDATA_W-1:0]  s_tdata,
	input  logic [bfa_pkg::TUSER_W-1:0]  s_tuser,
	output logic [bfa_pkg::TDATA_W-1:0]  m_tdata,
	output logic [bfa_pkg::TUSER_W-1:0]  m_tuser
);

	// Usage bitmap, one bit per unit, 1 means used.
	logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::NUM_WORDS];

	bfa_pkg::action_t              act_q;
	logic [bfa_pkg::FOUND_W-1:0]   idx_q;
	logic [bfa_pkg::CNT_W-1:0]     cnt_q;
	logic                          rd_valid_s1;
	logic [bfa_pkg::ADDR_W-1:0]    rd_addr_s1;
	logic [bfa_pkg::WORD_BITS-1:0] rdata_s1;
	bfa_pkg::status_t              res_status_q;
	logic [bfa_pkg::FOUND_W-1:0]   res_found_q;
	bfa_pkg::status_t              out_status_q;
	logic [bfa_pkg::FOUND_W-1:0]   out_found_q;

	logic [bfa_pkg::WORD_BITS-1:0] avail;
	logic [bfa_pkg::BIT_W-1:0]     hit_bit;
	logic [bfa_pkg::UNIT_W-1:0]    hit_unit;
	logic                          unit_ok;
	logic [bfa_pkg::ADDR_W-1:0]    idx_word;
	logic [bfa_pkg::BIT_W-1:0]     idx_bit;
	logic                          cnt_end;

	logic                          we;
	logic [bfa_pkg::ADDR_W-1:0]    waddr;
	logic [bfa_pkg::WORD_BITS-1:0] wdata;
	logic                          re;
	logic [bfa_pkg::ADDR_W-1:0]    raddr;

	assign idx_word = bfa_pkg::ADDR_W'(idx_q / bfa_pkg::WORD_BITS);
	assign idx_bit  = bfa_pkg::BIT_W'(idx_q % bfa_pkg::WORD_BITS);
	assign cnt_end  = (cnt_q == bfa_pkg::CNT_W'(bfa_pkg::NUM_WORDS));

	// Lowest free bit of the word just read.
	assign avail = ~rdata_s1;
	always_comb begin
		hit_bit = '0;
		for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				hit_bit = bfa_pkg::BIT_W'(i);
			end
		end
	end

	assign hit_unit = bfa_pkg::UNIT_W'(rd_addr_s1) * bfa_pkg::UNIT_W'(bfa_pkg::WORD_BITS)
			+ bfa_pkg::UNIT_W'(hit_bit);
	// Padding bits of a partial last word look free but are not units.
	assign unit_ok  = (hit_unit < bfa_pkg::UNIT_W'(bfa_pkg::MAP_UNITS));

	assign stat.act        = act_q;
	assign stat.idx_ok     = (bfa_pkg::CMP_W'(idx_q) < bfa_pkg::CMP_W'(bfa_pkg::MAP_UNITS));
	assign stat.sweep_last = (cnt_q == bfa_pkg::CNT_W'(bfa_pkg::NUM_WORDS - 1));
	assign stat.hit        = rd_valid_s1 && (|avail);
	assign stat.exhausted  = !rd_valid_s1 && cnt_end;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[bfa_pkg::ADDR_W-1:0];
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.mark_wr) begin
			we    = 1'b1;
			waddr = idx_word;
			wdata = rdata_s1 | (bfa_pkg::WORD_BITS'(1) << idx_bit);
		end else if (cmd.scan_commit) begin
			we    = (act_q == bfa_pkg::ACT_ALLOC) && unit_ok;
			waddr = rd_addr_s1;
			wdata = rdata_s1 | (bfa_pkg::WORD_BITS'(1) << hit_bit);
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = cnt_q[bfa_pkg::ADDR_W-1:0];
		if (cmd.scan_step) begin
			re = !cnt_end;
		end else if (cmd.mark_rd) begin
			re    = 1'b1;
			raddr = idx_word;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.sweep_init) begin
				cnt_q       <= '0;
				rd_valid_s1 <= 1'b0;
			end else if (cmd.clr_step) begin
				cnt_q <= cnt_q + bfa_pkg::CNT_W'(1);
			end else if (cmd.scan_step) begin
				rd_valid_s1 <= !cnt_end;
				if (!cnt_end) begin
					cnt_q <= cnt_q + bfa_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= bfa_pkg::action_t'(s_tuser[1:0]);
			idx_q <= s_tdata[bfa_pkg::FOUND_W-1:0];
		end
		if (cmd.scan_step && !cnt_end) begin
			rd_addr_s1 <= cnt_q[bfa_pkg::ADDR_W-1:0];
		end
		if (cmd.scan_commit) begin
			res_status_q <= unit_ok ? bfa_pkg::ST_OK : bfa_pkg::ST_FULL;
			res_found_q  <= unit_ok ? bfa_pkg::FOUND_W'(hit_unit) : '0;
		end else if (cmd.res_ok) begin
			res_status_q <= bfa_pkg::ST_OK;
			res_found_q  <= '0;
		end else if (cmd.res_full) begin
			res_status_q <= bfa_pkg::ST_FULL;
			res_found_q  <= '0;
		end else if (cmd.res_range) begin
			res_status_q <= bfa_pkg::ST_RANGE;
			res_found_q  <= '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
		end
	end

	assign m_tuser = out_status_q;
	assign m_tdata = bfa_pkg::TDATA_W'(out_found_q);

endmodule

/* rtl/bfa_ctrl.sv */
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  bfa_pkg::dp_stat_t stat,
	output bfa_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_INIT    = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_DECODE  = 7'b0000100,
		S_CLR     = 7'b0001000,
		S_SCAN    = 7'b0010000,
		S_MARK_WR = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.act)
					bfa_pkg::ACT_CLEAR: begin
						cmd.sweep_init = 1'b1;
						state_d        = S_CLR;
					end
					bfa_pkg::ACT_FIND, bfa_pkg::ACT_ALLOC: begin
						cmd.sweep_init = 1'b1;
						state_d        = S_SCAN;
					end
					bfa_pkg::ACT_MARK: begin
						if (stat.idx_ok) begin
							cmd.mark_rd = 1'b1;
							state_d     = S_MARK_WR;
						end else begin
							cmd.res_range = 1'b1;
							state_d       = S_DONE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.sweep_last) begin
					cmd.res_ok = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.scan_commit = 1'b1;
					state_d         = S_DONE;
				end else if (stat.exhausted) begin
					cmd.res_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				cmd.res_ok  = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/bitmap_first_free_allocator.sv */
// First-fit allocation bitmap with one usage bit per storage unit (1 = used).
// Commands arrive as words on the slave stream: tuser carries the action
// (clear map, find first free, mark unit used, allocate) and tdata the unit
// index, which only mark reads. Every command gives exactly one result word
// on the master stream: tuser carries the status (ok, map full, index out of
// range) and tdata the unit found, or zero.
// The map lives in a memory of NUM_WORDS words, and one word is read or
// written per cycle. Find and allocate scan the words from the lowest
// address, one per cycle, and stop at the first word with a free bit, or
// report the map full after the last word. Clear writes every word. Mark
// reads, updates and writes one word back. One command is worked on at a
// time. After reset the block clears every word of the map (2048 words at
// the default geometry) with s_tready low, then accepts commands.
// The result sits in an output register, so a stalled receiver does not hold
// up the next command; only when that command finishes while the previous
// result has still not been taken does the block wait before going idle.
module bitmap_first_free_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// Slave stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bfa_pkg::TDATA_W-1:0] s_tdata,   // [16:0] unit_index, rest zero
	input  logic [bfa_pkg::TUSER_W-1:0] s_tuser,   // [1:0] action
	// Master stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bfa_pkg::TDATA_W-1:0] m_tdata,   // [16:0] found_index, rest zero
	output logic [bfa_pkg::TUSER_W-1:0] m_tuser    // [1:0] status
);

	bfa_pkg::dp_cmd_t  cmd;
	bfa_pkg::dp_stat_t stat;

	// The controller sequences each command and owns both handshakes.
	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the bitmap memory, the sweep counter, the
	// first-free encoder and the result registers.
	bfa_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
